// File: rtl/hcws_pkg.sv
// Package for the hash cluster way selector: field widths, constants and
// the structs that pass between the lanes, the merge stage and the top level.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hcws_pkg;

   localparam int WAYS_DEFAULT = 3;

   localparam int KEY_W     = 16;
   localparam int DEPTH_W   = 8;
   localparam int GB_W      = 8;
   localparam int GEN_W     = 5;
   localparam int WAY_W     = KEY_W + DEPTH_W + GB_W;
   localparam int WAY_IDX_W = 2;
   localparam int REPL_W    = DEPTH_W + 1;

   localparam int RSP_FIELDS_W = 1 + WAY_IDX_W + 1 + GB_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [GB_W:0]   AGE_BIAS   = 9'd263;
   localparam logic [GB_W-1:0] AGE_MASK   = 8'hF8;
   localparam logic [GB_W-1:0] BOUND_MASK = 8'h07;

   localparam logic REG_GENERATION = 1'b0;

   typedef struct packed {
      logic                     qual;
      logic                     depth_nz;
      logic signed [REPL_W-1:0] rval;
      logic [GB_W-1:0]          new_gb;
   } lane_res_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_IDX_W-1:0] chosen_way;
      logic                 refresh;
      logic [GB_W-1:0]      new_genbound;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/hcws_lane.sv
// One way lane: tag match and empty check, replacement value and the
// refreshed generation byte. Depends on hcws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hcws_lane (
   input  wire logic [hcws_pkg::KEY_W-1:0]   probe_key,
   input  wire logic [hcws_pkg::KEY_W-1:0]   tag,
   input  wire logic [hcws_pkg::DEPTH_W-1:0] depth,
   input  wire logic [hcws_pkg::GB_W-1:0]    genbound,
   input  wire logic [hcws_pkg::GEN_W-1:0]   generation,
   output hcws_pkg::lane_res_type            result
);

   logic [hcws_pkg::GB_W-1:0] gen8;
   logic [hcws_pkg::GB_W:0]   age_sum;
   logic [hcws_pkg::GB_W-1:0] age;

   assign gen8    = {generation, {(hcws_pkg::GB_W - hcws_pkg::GEN_W){1'b0}}};
   assign age_sum = hcws_pkg::AGE_BIAS + {1'b0, gen8} - {1'b0, genbound};
   assign age     = age_sum[hcws_pkg::GB_W-1:0] & hcws_pkg::AGE_MASK;

   always_comb begin
      result.depth_nz = (depth != '0);
      result.qual     = (tag == probe_key) || (depth == '0);
      result.rval     = $signed({1'b0, depth} - {1'b0, age});
      result.new_gb   = gen8 | (genbound & hcws_pkg::BOUND_MASK);
   end

endmodule
`default_nettype wire

// File: rtl/hcws_merge.sv
// Merge stage: picks the first qualifying way, or else the way with the
// smallest replacement value. Depends on hcws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hcws_merge #(
   parameter int WAYS = hcws_pkg::WAYS_DEFAULT
) (
   input  hcws_pkg::lane_res_type lanes [WAYS],
   output hcws_pkg::rsp_type      rsp
);

   always_comb begin
      logic                               found;
      logic [hcws_pkg::WAY_IDX_W-1:0]     sel;
      logic [hcws_pkg::WAY_IDX_W-1:0]     victim;
      logic signed [hcws_pkg::REPL_W-1:0] best;

      found  = 1'b0;
      sel    = '0;
      victim = '0;
      best   = lanes[0].rval;
      for (int i = 0; i < WAYS; i++) begin
         if (!found && lanes[i].qual) begin
            found = 1'b1;
            sel   = hcws_pkg::WAY_IDX_W'(i);
         end
      end
      for (int i = 1; i < WAYS; i++) begin
         if ($signed(lanes[i].rval) < $signed(best)) begin
            best   = lanes[i].rval;
            victim = hcws_pkg::WAY_IDX_W'(i);
         end
      end

      if (found) begin
         rsp.hit          = lanes[sel].depth_nz;
         rsp.chosen_way   = sel;
         rsp.refresh      = 1'b1;
         rsp.new_genbound = lanes[sel].new_gb;
      end else begin
         rsp.hit          = 1'b0;
         rsp.chosen_way   = victim;
         rsp.refresh      = 1'b0;
         rsp.new_genbound = '0;
      end
   end

endmodule
`default_nettype wire

// File: rtl/hash_cluster_way_select.sv
// A request passes the lane results register, then the output register.
// Throughput: one request per cycle unless the output stalls; the lane results
// and output registers advance together whenever the output is free or taken.
// Reset: synchronous, active high; clears both valid flags and sets the
// generation register to zero.
// Top level of the hash cluster way selector. Depends on hcws_pkg,
// hcws_lane and hcws_merge.
`timescale 1ns / 1ps
`default_nettype none
module hash_cluster_way_select #(
   parameter int WAYS = hcws_pkg::WAYS_DEFAULT
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           req_tvalid,
   output      logic                                           req_tready,
   // probe_key, then per way: tag, depth, genbound
   input  wire logic [hcws_pkg::KEY_W+WAYS*hcws_pkg::WAY_W-1:0] req_tdata,
   output      logic                                           rsp_tvalid,
   input  wire logic                                           rsp_tready,
   // hit, chosen_way, refresh, new_genbound, zero padding
   output      logic [hcws_pkg::RSP_DATA_W-1:0]                rsp_tdata,
   input  wire logic                                           csr_psel,
   input  wire logic                                           csr_penable,
   input  wire logic                                           csr_pwrite,
   input  wire logic [hcws_pkg::CSR_ADDR_W-1:0]                csr_paddr,
   input  wire logic [hcws_pkg::CSR_DATA_W-1:0]                csr_pwdata,
   output      logic [hcws_pkg::CSR_DATA_W-1:0]                csr_prdata,
   output      logic                                           csr_pready
);

   localparam int PAD_W = hcws_pkg::RSP_DATA_W - hcws_pkg::RSP_FIELDS_W;

   logic [hcws_pkg::GEN_W-1:0] generation_ff;
   logic [hcws_pkg::GEN_W-1:0] generation_in;
   logic                       csr_wr;

   hcws_pkg::lane_res_type lane_res [WAYS];
   hcws_pkg::lane_res_type lane_ff  [WAYS];
   hcws_pkg::rsp_type      merge_rsp;
   hcws_pkg::rsp_type      rsp_ff;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   logic                   s1_en;
   logic                   s2_en;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      generation_in = generation_ff;
      if (csr_wr && (csr_paddr[2] == hcws_pkg::REG_GENERATION)) begin
         generation_in = csr_pwdata[hcws_pkg::GEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == hcws_pkg::REG_GENERATION) begin
         csr_prdata = {{(hcws_pkg::CSR_DATA_W - hcws_pkg::GEN_W){1'b0}}, generation_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         generation_ff <= '0;
      end else begin
         generation_ff <= generation_in;
      end
   end

   for (genvar i = 0; i < WAYS; i++) begin : g_lane
      localparam int BASE = hcws_pkg::KEY_W + i * hcws_pkg::WAY_W;
      hcws_lane u_lane (
         .probe_key  (req_tdata[hcws_pkg::KEY_W-1:0]),
         .tag        (req_tdata[BASE +: hcws_pkg::KEY_W]),
         .depth      (req_tdata[BASE + hcws_pkg::KEY_W +: hcws_pkg::DEPTH_W]),
         .genbound   (req_tdata[BASE + hcws_pkg::KEY_W + hcws_pkg::DEPTH_W +: hcws_pkg::GB_W]),
         .generation (generation_ff),
         .result     (lane_res[i])
      );
   end

   hcws_merge #(.WAYS(WAYS)) u_merge (
      .lanes (lane_ff),
      .rsp   (merge_rsp)
   );

   assign s2_en       = !s2_valid_ff || rsp_tready;
   assign s1_en       = !s1_valid_ff || s2_en;
   assign req_tready  = s1_en;
   assign s1_valid_in = s1_en ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         lane_ff <= lane_res;
      end
      if (s2_en) begin
         rsp_ff <= merge_rsp;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ff.new_genbound, rsp_ff.refresh,
                        rsp_ff.chosen_way, rsp_ff.hit};

endmodule
`default_nettype wire

// File: rtl/hcws_checker.sv
// Port-level checker for hash_cluster_way_select and the bind that attaches
// it. Depends on hcws_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none
module hcws_checker #(
   parameter int WAYS = hcws_pkg::WAYS_DEFAULT
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [hcws_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic                           c_hit;
   logic [hcws_pkg::WAY_IDX_W-1:0] c_way;
   logic                           c_refresh;
   logic [hcws_pkg::GB_W-1:0]      c_gb;

   assign c_hit     = rsp_tdata[0];
   assign c_way     = rsp_tdata[hcws_pkg::WAY_IDX_W:1];
   assign c_refresh = rsp_tdata[hcws_pkg::WAY_IDX_W+1];
   assign c_gb      = rsp_tdata[hcws_pkg::WAY_IDX_W+2 +: hcws_pkg::GB_W];

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_way_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(c_way) < WAYS))
      else $error("chosen way out of range");

   a_hit_refresh: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && c_hit |-> c_refresh)
      else $error("hit without refresh");

   a_victim_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !c_refresh |-> (c_gb == '0))
      else $error("victim response carries a generation byte");

endmodule

bind hash_cluster_way_select hcws_checker #(.WAYS(WAYS)) u_hcws_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// File: tb/sv/hash_cluster_way_select_test.sv
// Self-checking testbench for hash_cluster_way_select: random and directed probes,
// a built-in way selection predictor and random stalls on both stream sides.
// Depends on hcws_pkg and the RTL of the way selector.
`timescale 1ns / 1ps
module hash_cluster_way_select_test;

   localparam int KEY_W        = hcws_pkg::KEY_W;
   localparam int DEPTH_W      = hcws_pkg::DEPTH_W;
   localparam int GB_W         = hcws_pkg::GB_W;
   localparam int GEN_W        = hcws_pkg::GEN_W;
   localparam int WAY_W        = hcws_pkg::WAY_W;
   localparam int WAY_IDX_W    = hcws_pkg::WAY_IDX_W;
   localparam int WAYS_DEFAULT = hcws_pkg::WAYS_DEFAULT;
   localparam int RSP_DATA_W   = hcws_pkg::RSP_DATA_W;
   localparam int CSR_ADDR_W   = hcws_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = hcws_pkg::CSR_DATA_W;

   localparam int REQ_W = KEY_W + WAYS_DEFAULT * WAY_W;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_STALL_CYCLES = 200;
   localparam logic [CSR_ADDR_W-1:0] GEN_ADDR =
      CSR_ADDR_W'(4 * int'(hcws_pkg::REG_GENERATION));
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4);

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   logic [REQ_W-1:0] pending_probes[$];
   hcws_pkg::rsp_type predicted_picks[$];
   hcws_pkg::rsp_type want;
   logic [GEN_W-1:0] gen_now = '0;
   bit req_taken = 0;
   bit steady = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   int stall_left = 0;
   int stall_requests = 0;
   int stall_served = 0;
   int idle_cycles = 0;
   int errors = 0;
   int probes_queued = 0;
   int probes_sent = 0;
   int responses_seen = 0;
   int hit_count = 0;
   int empty_count = 0;
   int victim_count = 0;
   int csr_writes = 0;

   hash_cluster_way_select u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),     // probe_key, then per way: tag, depth, genbound
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),     // hit, chosen_way, refresh, new_genbound, zero padding
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic hcws_pkg::rsp_type pick_way(input logic [GEN_W-1:0] gen,
                                                  input logic [REQ_W-1:0] probe);
      hcws_pkg::rsp_type pick;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] tag;
      logic [DEPTH_W-1:0] depth;
      logic [GB_W-1:0] gb;
      bit found;
      int age;
      int score;
      int best;
      pick = '0;
      found = 0;
      best = 0;
      key = probe[KEY_W-1:0];
      for (int w = 0; w < WAYS_DEFAULT; w++) begin
         tag = probe[KEY_W + w * WAY_W +: KEY_W];
         depth = probe[KEY_W + w * WAY_W + KEY_W +: DEPTH_W];
         gb = probe[KEY_W + w * WAY_W + KEY_W + DEPTH_W +: GB_W];
         if (!found && (tag == key || depth == 0)) begin
            found = 1;
            pick.hit = (depth != 0);
            pick.chosen_way = WAY_IDX_W'(w);
            pick.refresh = 1'b1;
            pick.new_genbound = {gen, gb[2:0]};
         end
      end
      if (!found) begin
         for (int w = 0; w < WAYS_DEFAULT; w++) begin
            depth = probe[KEY_W + w * WAY_W + KEY_W +: DEPTH_W];
            gb = probe[KEY_W + w * WAY_W + KEY_W + DEPTH_W +: GB_W];
            age = (int'(hcws_pkg::AGE_BIAS) + int'(gen) * 8 - int'(gb))
                  & int'(hcws_pkg::AGE_MASK);
            score = int'(depth) - age;
            if (w == 0 || score < best) begin
               best = score;
               pick.chosen_way = WAY_IDX_W'(w);
            end
         end
      end
      return pick;
   endfunction

   function automatic logic [REQ_W-1:0] pack_probe(
         input logic [KEY_W-1:0] key,
         input logic [WAYS_DEFAULT-1:0][KEY_W-1:0] tags,
         input logic [WAYS_DEFAULT-1:0][DEPTH_W-1:0] depths,
         input logic [WAYS_DEFAULT-1:0][GB_W-1:0] gbs);
      logic [REQ_W-1:0] probe;
      probe = '0;
      probe[KEY_W-1:0] = key;
      for (int w = 0; w < WAYS_DEFAULT; w++) begin
         probe[KEY_W + w * WAY_W +: KEY_W] = tags[w];
         probe[KEY_W + w * WAY_W + KEY_W +: DEPTH_W] = depths[w];
         probe[KEY_W + w * WAY_W + KEY_W + DEPTH_W +: GB_W] = gbs[w];
      end
      return probe;
   endfunction

   function automatic logic [REQ_W-1:0] random_probe(input logic [GEN_W-1:0] gen);
      logic [KEY_W-1:0] key;
      logic [WAYS_DEFAULT-1:0][KEY_W-1:0] tags;
      logic [WAYS_DEFAULT-1:0][DEPTH_W-1:0] depths;
      logic [WAYS_DEFAULT-1:0][GB_W-1:0] gbs;
      logic [GEN_W-1:0] age_step;
      logic [2:0] bound;
      int kind;
      int pick;
      int base;
      int d;
      key = KEY_W'($urandom);
      kind = $urandom_range(0, 99);
      base = $urandom_range(1, 255);
      pick = $urandom_range(0, WAYS_DEFAULT - 1);
      for (int w = 0; w < WAYS_DEFAULT; w++) begin
         tags[w] = KEY_W'($urandom);
         if (kind < 90 && tags[w] == key) begin
            tags[w] = ~key;
         end
         if (kind < 90) begin
            d = base + int'($urandom_range(0, 16)) - 8;
            if (d < 1) d = 1;
            if (d > 255) d = 255;
            depths[w] = DEPTH_W'(d);
         end else begin
            depths[w] = DEPTH_W'($urandom);
         end
         if ($urandom_range(0, 1) == 1) begin
            age_step = GEN_W'($urandom_range(0, 3));
            bound = 3'($urandom);
            gbs[w] = {gen - age_step, bound};
         end else begin
            gbs[w] = GB_W'($urandom);
         end
      end
      if (kind < 30) begin
         tags[pick] = key;
         if ($urandom_range(0, 3) == 0) depths[pick] = '0;
      end else if (kind < 45) begin
         depths[pick] = '0;
      end
      return pack_probe(key, tags, depths, gbs);
   endfunction

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   task automatic add_probe(input logic [KEY_W-1:0] key,
                            input logic [KEY_W-1:0] t0, input logic [DEPTH_W-1:0] d0,
                            input logic [GB_W-1:0] g0,
                            input logic [KEY_W-1:0] t1, input logic [DEPTH_W-1:0] d1,
                            input logic [GB_W-1:0] g1,
                            input logic [KEY_W-1:0] t2, input logic [DEPTH_W-1:0] d2,
                            input logic [GB_W-1:0] g2);
      pending_probes.push_back(pack_probe(key, {t2, t1, t0}, {d2, d1, d0}, {g2, g1, g0}));
      probes_queued++;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      while (pending_probes.size() != 0 || responses_seen != probes_queued) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic random_phase(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] value,
                               input int count, input bit no_idle, input bit long_stall);
      csr_write(addr, value);
      steady = no_idle;
      if (long_stall) stall_requests++;
      repeat (count) begin
         pending_probes.push_back(random_probe(gen_now));
         probes_queued++;
      end
      drain();
   endtask

   function automatic void check_field(input string name, input int want_val,
                                       input int got_val);
      if (want_val != got_val) begin
         $display("%0t: response mismatch in %s: expected %0h, actual %0h",
                  $time, name, want_val, got_val);
         errors++;
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         req_tvalid <= 1'b1;
      end else if (!steady && req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_probes.size() > 0) begin
         req_tdata <= pending_probes.pop_front();
         req_tvalid <= 1'b1;
         req_gap = steady ? 0 : rand_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_served != stall_requests) begin
         stall_served++;
         stall_left = LONG_STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = rand_gap();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken = 0;
         gen_now = '0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predicted_picks.push_back(pick_way(gen_now, req_tdata));
            probes_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (predicted_picks.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = predicted_picks.pop_front();
               if (want.hit) hit_count++;
               else if (want.refresh) empty_count++;
               else victim_count++;
               check_field("hit", int'(want.hit), int'(rsp_tdata[0]));
               check_field("chosen_way", int'(want.chosen_way), int'(rsp_tdata[2:1]));
               check_field("refresh", int'(want.refresh), int'(rsp_tdata[3]));
               check_field("new_genbound", int'(want.new_genbound), int'(rsp_tdata[11:4]));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            csr_writes++;
            if (csr_paddr == GEN_ADDR) gen_now = csr_pwdata[GEN_W-1:0];
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(GEN_ADDR, '0);
      add_probe(16'h0000, 16'h0000, 8'd0, 8'h00, 16'h0000, 8'd0, 8'h00,
                16'h0000, 8'd0, 8'h00);
      add_probe(16'hA5C3, 16'hA5C3, 8'd12, 8'h05, 16'h0001, 8'd3, 8'h00,
                16'h0002, 8'd4, 8'h00);
      add_probe(16'hA5C3, 16'h0001, 8'd10, 8'h00, 16'hA5C3, 8'd255, 8'hFF,
                16'h0002, 8'd3, 8'h00);
      add_probe(16'hA5C3, 16'h0001, 8'd10, 8'h00, 16'h0002, 8'd20, 8'h00,
                16'hA5C3, 8'd1, 8'h07);
      add_probe(16'hA5C3, 16'h0001, 8'd10, 8'h00, 16'h0002, 8'd20, 8'h00,
                16'h0003, 8'd0, 8'hFE);
      add_probe(16'hA5C3, 16'h0001, 8'd10, 8'h00, 16'h0002, 8'd0, 8'h13,
                16'hA5C3, 8'd40, 8'h00);
      add_probe(16'hA5C3, 16'h0001, 8'd0, 8'hFF, 16'hA5C3, 8'd9, 8'h00,
                16'h0003, 8'd0, 8'h00);
      add_probe(16'hFFFF, 16'hFFFF, 8'd0, 8'hFF, 16'hFFFF, 8'd255, 8'hFF,
                16'hFFFF, 8'd255, 8'hFF);
      add_probe(16'hFFFF, 16'hFFFF, 8'd255, 8'hFF, 16'h0000, 8'd0, 8'h00,
                16'hFFFF, 8'd255, 8'hFF);
      add_probe(16'hFFFF, 16'hFFFE, 8'd255, 8'hFF, 16'h7FFF, 8'd255, 8'hFF,
                16'h0000, 8'd255, 8'hFF);
      add_probe(16'hA5C3, 16'h0000, 8'd50, 8'h00, 16'h0001, 8'd30, 8'h00,
                16'h0002, 8'd40, 8'h00);
      add_probe(16'hA5C3, 16'h0000, 8'd50, 8'h00, 16'h0001, 8'd60, 8'h00,
                16'h0002, 8'd20, 8'h00);
      add_probe(16'hA5C3, 16'h0000, 8'd50, 8'h00, 16'h0001, 8'd20, 8'h00,
                16'h0002, 8'd20, 8'h00);
      add_probe(16'hA5C3, 16'h0000, 8'd100, 8'h00, 16'h0001, 8'd100, 8'h08,
                16'h0002, 8'd100, 8'h80);
      add_probe(16'hA5C3, 16'h0000, 8'd1, 8'h08, 16'h0001, 8'd1, 8'h0F,
                16'h0002, 8'd255, 8'h00);
      add_probe(16'h5A5A, 16'hA5A5, 8'h80, 8'h7F, 16'h5A5B, 8'h7F, 8'h80,
                16'hDA5A, 8'h01, 8'hF8);
      add_probe(16'h0001, 16'h0000, 8'd77, 8'h55, 16'h0001, 8'd1, 8'hF8,
                16'h0002, 8'd0, 8'hAA);
      add_probe(16'h8000, 16'h0000, 8'd200, 8'hF0, 16'h4000, 8'd200, 8'h30,
                16'h8001, 8'd199, 8'h00);
      drain();

      random_phase(GEN_ADDR, 32'd31, 120, 0, 0);
      random_phase(GEN_ADDR, 32'hFFFF_FFE5, 100, 1, 1);
      random_phase(UNUSED_ADDR, 32'd9, 80, 0, 0);
      random_phase(GEN_ADDR, $urandom, 110, 0, 0);
      random_phase(GEN_ADDR, $urandom_range(0, 31), 110, 1, 0);
      random_phase(GEN_ADDR, $urandom_range(0, 31), 110, 0, 0);

      repeat (10) @(negedge clock);
      $display("Run covered %0d probes and %0d responses across %0d register writes.",
               probes_sent, responses_seen, csr_writes);
      $display("Outcomes: %0d hits, %0d empty-way refreshes, %0d victim picks.",
               hit_count, empty_count, victim_count);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
